// ===== src/sbde_pkg.sv =====
// Shared types and constants for the distance-to-eye sorter.
package sbde_pkg;

  localparam int POS_W  = 16;
  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int KEY_W  = 36;
  localparam int OID_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_EYE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_Z = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_flag_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_cmd_t;

endpackage

// ===== src/sbde_keygen.sv =====
// Three-stage squared-distance key pipeline: differences, squares, sum.
module sbde_keygen #(
  parameter int ID_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  logic [ID_BITS-1:0]                 id,
  input  logic signed [sbde_pkg::POS_W-1:0]  pos_x,
  input  logic signed [sbde_pkg::POS_W-1:0]  pos_y,
  input  logic signed [sbde_pkg::POS_W-1:0]  pos_z,
  input  logic                               last,
  input  logic signed [sbde_pkg::POS_W-1:0]  eye_x,
  input  logic signed [sbde_pkg::POS_W-1:0]  eye_y,
  input  logic signed [sbde_pkg::POS_W-1:0]  eye_z,
  output sbde_pkg::stage_flag_t              flag,
  output sbde_pkg::key_t                     key,
  output logic [ID_BITS-1:0]                 key_id,
  output logic                               last_pending
);
  import sbde_pkg::*;

  stage_flag_t f1_r, f2_r, f3_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic [SQ_W-1:0] sqx_r, sqy_r, sqz_r;
  logic signed [SQ_W-1:0] px_sq, py_sq, pz_sq;
  logic [ID_BITS-1:0] id1_r, id2_r, id3_r;
  key_t key_r;

  assign px_sq = dx_r * dx_r;
  assign py_sq = dy_r * dy_r;
  assign pz_sq = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r <= '0;
      f2_r <= '0;
      f3_r <= '0;
    end else begin
      f1_r <= '{valid: fire, last: last};
      f2_r <= f1_r;
      f3_r <= f2_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= DIFF_W'(pos_x) - DIFF_W'(eye_x);
    dy_r  <= DIFF_W'(pos_y) - DIFF_W'(eye_y);
    dz_r  <= DIFF_W'(pos_z) - DIFF_W'(eye_z);
    id1_r <= id;
    sqx_r <= unsigned'(px_sq);
    sqy_r <= unsigned'(py_sq);
    sqz_r <= unsigned'(pz_sq);
    id2_r <= id1_r;
    key_r <= KEY_W'(sqx_r) + KEY_W'(sqy_r) + KEY_W'(sqz_r);
    id3_r <= id2_r;
  end

  assign flag   = f3_r;
  assign key    = key_r;
  assign key_id = id3_r;
  assign last_pending = (f1_r.valid && f1_r.last) || (f2_r.valid && f2_r.last) ||
                        (f3_r.valid && f3_r.last);

endmodule

// ===== src/sbde_cell.sv =====
// One slot of the insertion chain: holds a key and handle, shifts right on insert, left on emit.
module sbde_cell #(
  parameter int IDX     = 0,
  parameter int ID_BITS = 16,
  parameter int FILL_W  = 6
) (
  input  logic                 clk,
  input  sbde_pkg::cell_cmd_t  cmd,
  input  sbde_pkg::key_t       new_key,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic [FILL_W-1:0]    fill,
  input  sbde_pkg::key_t       left_key,
  input  logic [ID_BITS-1:0]   left_id,
  input  logic                 left_gt,
  input  sbde_pkg::key_t       right_key,
  input  logic [ID_BITS-1:0]   right_id,
  output sbde_pkg::key_t       key,
  output logic [ID_BITS-1:0]   id,
  output logic                 gt
);
  import sbde_pkg::*;

  localparam logic [FILL_W-1:0] IDX_C = FILL_W'(IDX);

  key_t key_r, key_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;

  assign gt = (IDX_C < fill) && (key_r > new_key);

  always_comb begin
    key_nxt = key_r;
    id_nxt  = id_r;
    if (cmd.ins) begin
      if (left_gt) begin
        key_nxt = left_key;
        id_nxt  = left_id;
      end else if (gt || fill == IDX_C) begin
        key_nxt = new_key;
        id_nxt  = new_id;
      end
    end else if (cmd.shift) begin
      key_nxt = right_key;
      id_nxt  = right_id;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
  end

  assign key = key_r;
  assign id  = id_r;

endmodule

// ===== src/sort_by_distance_to_eye_top.sv =====
// Top level of the distance-to-eye sorter: key pipeline, insertion chain and batch control.
//
// Objects enter one per cycle while in_stall is low. Each passes through the key pipeline
// (difference, square, sum) and is then placed into a chain of MAX_ITEMS cells; every
// cell compares its key with the new one at once, so insertion does not depend on how
// full the chain is. Once the batch-end object is accepted, input stalls until the batch
// is delivered: results leave nearest first from the head cell, one per cycle unless
// out_stall holds them, the chain shifting one slot toward the head per transaction.
// Objects beyond MAX_ITEMS are discarded and every result of that batch shows dropped.
module sort_by_distance_to_eye_top #(
  parameter int MAX_ITEMS = 32,
  parameter int ID_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [sbde_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sbde_pkg::POS_W-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sbde_pkg::OID_W-1:0]            in_object_id,
  input  logic signed [sbde_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [sbde_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [sbde_pkg::POS_W-1:0]     in_pos_z,
  input  logic                                  in_batch_end,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sbde_pkg::OID_W-1:0]            out_sorted_id,
  output logic [sbde_pkg::KEY_W-1:0]            out_distance_sq,
  output logic                                  out_run_last,
  output logic                                  out_dropped
);
  import sbde_pkg::*;

  localparam int FILL_W = $clog2(MAX_ITEMS + 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(MAX_ITEMS);
  localparam logic [FILL_W-1:0] ONE  = FILL_W'(1);

  logic signed [POS_W-1:0] eye_x_r, eye_y_r, eye_z_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic emit_r, emit_nxt;
  logic ovf_r, ovf_nxt;

  logic in_fire, out_fire, ins, pending;
  logic [ID_BITS-1:0] in_id;
  stage_flag_t kg_flag;
  key_t kg_key;
  logic [ID_BITS-1:0] kg_id;
  cell_cmd_t cmd;

  key_t               c_key [MAX_ITEMS];
  logic [ID_BITS-1:0] c_id  [MAX_ITEMS];
  logic               c_gt  [MAX_ITEMS];

  generate
    if (ID_BITS >= OID_W) begin : g_id_wide
      assign in_id         = ID_BITS'(in_object_id);
      assign out_sorted_id = c_id[0][OID_W-1:0];
    end else begin : g_id_narrow
      assign in_id         = in_object_id[ID_BITS-1:0];
      assign out_sorted_id = OID_W'(c_id[0]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_x_r <= '0;
      eye_y_r <= '0;
      eye_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EYE_X: eye_x_r <= cfg_wdata;
        CFG_EYE_Y: eye_y_r <= cfg_wdata;
        CFG_EYE_Z: eye_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = emit_r || pending;
  assign in_fire  = in_valid && !in_stall;

  sbde_keygen #(.ID_BITS(ID_BITS)) u_keygen (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .id           (in_id),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .pos_z        (in_pos_z),
    .last         (in_batch_end),
    .eye_x        (eye_x_r),
    .eye_y        (eye_y_r),
    .eye_z        (eye_z_r),
    .flag         (kg_flag),
    .key          (kg_key),
    .key_id       (kg_id),
    .last_pending (pending)
  );

  assign out_valid = emit_r;
  assign out_fire  = out_valid && !out_stall;
  assign ins       = kg_flag.valid && (fill_r != FULL);
  assign cmd       = '{ins: ins, shift: out_fire};

  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      key_t               lk, rk;
      logic [ID_BITS-1:0] lid, rid;
      logic               lgt;
      if (i == 0) begin : g_head
        assign lk  = '0;
        assign lid = '0;
        assign lgt = 1'b0;
      end else begin : g_body
        assign lk  = c_key[i-1];
        assign lid = c_id[i-1];
        assign lgt = c_gt[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_tail
        assign rk  = c_key[i];
        assign rid = c_id[i];
      end else begin : g_mid
        assign rk  = c_key[i+1];
        assign rid = c_id[i+1];
      end
      sbde_cell #(.IDX(i), .ID_BITS(ID_BITS), .FILL_W(FILL_W)) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .new_key   (kg_key),
        .new_id    (kg_id),
        .fill      (fill_r),
        .left_key  (lk),
        .left_id   (lid),
        .left_gt   (lgt),
        .right_key (rk),
        .right_id  (rid),
        .key       (c_key[i]),
        .id        (c_id[i]),
        .gt        (c_gt[i])
      );
    end
  endgenerate

  always_comb begin
    fill_nxt = fill_r;
    emit_nxt = emit_r;
    ovf_nxt  = ovf_r;
    if (ins) begin
      fill_nxt = fill_r + ONE;
    end else if (out_fire) begin
      fill_nxt = fill_r - ONE;
    end
    if (kg_flag.valid && !ins) begin
      ovf_nxt = 1'b1;
    end
    if (kg_flag.valid && kg_flag.last) begin
      emit_nxt = 1'b1;
    end else if (out_fire && fill_r == ONE) begin
      emit_nxt = 1'b0;
      ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      emit_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      emit_r <= emit_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_distance_sq = c_key[0];
  assign out_run_last    = (fill_r == ONE);
  assign out_dropped     = ovf_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count above capacity");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> fill_r != '0)
    else $error("emitting from an empty chain");

  a_batch_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_run_last |=> !emit_r && fill_r == '0 && !ovf_r)
    else $error("batch state not cleared after final result");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_run_last |=> out_valid && $past(out_distance_sq) <= out_distance_sq)
    else $error("results out of distance order");

  a_no_insert_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r && !$past(kg_flag.valid) |-> !kg_flag.valid)
    else $error("object reached chain during emission");

endmodule
